// ===== rtl/conv3x3_box_or_laplacian_core_assert.svh =====
// Assertion macros shared by the convolution core.
`ifndef CONV3X3_BOX_OR_LAPLACIAN_CORE_ASSERT_SVH
`define CONV3X3_BOX_OR_LAPLACIAN_CORE_ASSERT_SVH

// The antecedent and the consequent hold in the same cycle.
`define C3BL_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("c3bl assertion failed");

// The consequent holds in the cycle after the antecedent.
`define C3BL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("c3bl assertion failed");

`endif

// ===== rtl/c3bl_pkg.sv =====
// Types and constants shared by the 3x3 convolution core.
package c3bl_pkg;

  localparam int PIX_W      = 8;
  localparam int GEOM_LIMIT = 1024;
  localparam int COL_W      = 10;
  localparam int ROW_W      = 11;
  localparam int GEOM_W     = 11;
  localparam int COLSUM_W   = 10;
  localparam int SUM_W      = 12;
  localparam int PROD_W     = 24;
  localparam int CFG_INDEX_W = 2;

  typedef logic [PIX_W-1:0]  pix_t;
  typedef logic [COL_W-1:0]  col_count_t;
  typedef logic [ROW_W-1:0]  row_count_t;
  typedef logic [GEOM_W-1:0] geom_t;

  typedef struct packed {
    pix_t top;
    pix_t mid;
    pix_t bot;
  } column_t;

  typedef struct packed {
    logic emit;
    logic last;
    logic skip_top;
    logic skip_bottom;
    logic skip_left;
    logic skip_right;
  } pos_info_t;

  localparam logic [CFG_INDEX_W-1:0] REG_KERNEL_MODE  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

  localparam logic MODE_BOX       = 1'b0;
  localparam logic MODE_LAPLACIAN = 1'b1;
  localparam logic OP_PIXEL       = 1'b0;
  localparam logic OP_DRAIN       = 1'b1;

  localparam geom_t WIDTH_RESET  = 11'd512;
  localparam geom_t HEIGHT_RESET = 11'd512;

  localparam logic [SUM_W-1:0] DIV9_RECIP = 12'd3641;
  localparam int               DIV9_SHIFT = 15;

endpackage

// ===== rtl/c3bl_raster.sv =====
// Raster position tracking, border flags and frame end detection.
module c3bl_raster import c3bl_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic       geom_write,
  input  geom_t      image_width,
  input  geom_t      image_height,
  output col_count_t col,
  output pos_info_t  info
);

  localparam int WIDTH_CAP = (MAX_WIDTH < GEOM_LIMIT) ? MAX_WIDTH : GEOM_LIMIT;

  col_count_t col_count, col_count_next;
  row_count_t row_count, row_count_next;
  geom_t      w, h, col_inc, r, c, row_inc, h_inc;
  logic       emit_raw;

  always_comb begin
    w = image_width;
    if (w < 11'd3) begin
      w = 11'd3;
    end else if (w > GEOM_W'(WIDTH_CAP)) begin
      w = GEOM_W'(WIDTH_CAP);
    end
    h = image_height;
    if (h < 11'd1) begin
      h = 11'd1;
    end else if (h > GEOM_W'(GEOM_LIMIT)) begin
      h = GEOM_W'(GEOM_LIMIT);
    end
  end

  always_comb begin
    col_inc = GEOM_W'(col_count) + 11'd1;
    h_inc   = h + 11'd1;
    row_inc = row_count + 11'd1;
    if (col_count == '0) begin
      emit_raw = (row_count >= 11'd2);
      r        = row_count - 11'd2;
      c        = w - 11'd1;
    end else begin
      emit_raw = (row_count >= 11'd1);
      r        = row_count - 11'd1;
      c        = GEOM_W'(col_count) - 11'd1;
    end
    info.emit        = emit_raw && (r < h);
    info.last        = info.emit && (r == h - 11'd1) && (c == w - 11'd1);
    info.skip_top    = (r == '0);
    info.skip_bottom = ({1'b0, r} + 12'd1) >= {1'b0, h};
    info.skip_left   = (c == '0);
    info.skip_right  = ({1'b0, c} + 12'd1) >= {1'b0, w};

    col_count_next = col_count;
    row_count_next = row_count;
    if (col_inc >= w) begin
      col_count_next = '0;
      row_count_next = (row_inc > h_inc) ? h_inc : row_inc;
    end else begin
      col_count_next = col_inc[COL_W-1:0];
    end
    if (info.last) begin
      col_count_next = '0;
      row_count_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || geom_write) begin
      col_count <= '0;
      row_count <= '0;
    end else if (accept) begin
      col_count <= col_count_next;
      row_count <= row_count_next;
    end
  end

  assign col = col_count;

endmodule

// ===== rtl/c3bl_line_buf.sv =====
// Two line stores that hold the previous two image rows.
module c3bl_line_buf import c3bl_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic       clk,
  input  logic       accept,
  input  col_count_t col,
  input  pix_t       pixel,
  input  logic       move,
  output pix_t       rd_top,
  output pix_t       rd_mid
);

  localparam int AW = $clog2(MAX_WIDTH);

  pix_t          upper_mem [MAX_WIDTH];
  pix_t          lower_mem [MAX_WIDTH];
  logic [AW-1:0] addr;
  logic [AW-1:0] addr_q;

  assign addr = AW'(col);

  always_ff @(posedge clk) begin
    if (accept) begin
      lower_mem[addr] <= pixel;
      rd_mid          <= lower_mem[addr];
      addr_q          <= addr;
      // The upper store is written from the registered address, so a read of the same column
      // takes the value that is being written.
      if (move && (addr_q == addr)) begin
        rd_top <= rd_mid;
      end else begin
        rd_top <= upper_mem[addr];
      end
    end
    if (move) begin
      upper_mem[addr_q] <= rd_mid;
    end
  end

endmodule

// ===== rtl/c3bl_cell.sv =====
// One window column cell: holds three pixels and gives its masked sum.
module c3bl_cell import c3bl_pkg::*; (
  input  logic                clk,
  input  logic                shift,
  input  column_t             col_in,
  input  logic                skip_col,
  input  logic                skip_top,
  input  logic                skip_bottom,
  output column_t             col_out,
  output logic [COLSUM_W-1:0] col_sum
);

  column_t held;

  always_ff @(posedge clk) begin
    if (shift) begin
      held <= col_in;
    end
  end

  always_comb begin
    if (skip_col) begin
      col_sum = '0;
    end else begin
      col_sum = (skip_top ? 10'd0 : COLSUM_W'(held.top)) + COLSUM_W'(held.mid)
              + (skip_bottom ? 10'd0 : COLSUM_W'(held.bot));
    end
  end

  assign col_out = held;

endmodule

// ===== rtl/conv3x3_box_or_laplacian_core.sv =====
// Top level of the streaming 3x3 box mean and Laplacian filter.
//
//   channel  handshake             payload               direction
//   in       in_valid / in_stall   operation, pixel_in   into the core
//   out      out_valid / out_stall pixel_out, frame_last out of the core
//   cfg      cfg_valid / cfg_ready cfg_index, cfg_data   into the core
//
// One word is taken each clock while in_stall is low; the pipeline is five registers deep from input to output.
// A result leaves through those registers after the word that completes its window, W+1 words later.
// Reset clears control state only; the line stores are never cleared, the border masks hide them.
// An output stall parks one result in a skid register and in_stall rises the cycle after.
`include "conv3x3_box_or_laplacian_core_assert.svh"

module conv3x3_box_or_laplacian_core import c3bl_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   operation,
  input  pix_t                   pixel_in,
  output logic                   out_valid,
  input  logic                   out_stall,
  output pix_t                   pixel_out,
  output logic                   frame_last,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  geom_t                  cfg_data
);

  logic  kernel_mode;
  geom_t image_width, image_height;
  logic  cfg_write, geom_write;

  logic       en, accept;
  pix_t       pix_v;
  col_count_t col;
  pos_info_t  info;

  logic      a_valid;
  pos_info_t a_info;
  pix_t      a_pix;
  pix_t      rd_top, rd_mid;

  logic      b_valid;
  pos_info_t b_info;
  column_t   feed, col_right, col_centre;
  logic [COLSUM_W-1:0] sum_left, sum_centre, sum_right;

  logic             c_valid, c_last;
  logic [SUM_W-1:0] c_sum;
  pix_t             c_centre;

  logic               d_valid, d_last;
  logic [PROD_W-1:0]  d_prod;
  pix_t               d_lap;
  logic [SUM_W-1:0]   centre9;
  logic signed [SUM_W:0] lap;
  pix_t               lap_clamped, result;

  logic pop, push;
  logic skid_valid, skid_last;
  pix_t skid_pix;

  // Configuration registers.
  assign cfg_ready  = 1'b1;
  assign cfg_write  = cfg_valid && cfg_ready;
  assign geom_write = cfg_write &&
                      ((cfg_index == REG_IMAGE_WIDTH) || (cfg_index == REG_IMAGE_HEIGHT));

  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_mode  <= MODE_LAPLACIAN;
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_KERNEL_MODE:  kernel_mode  <= cfg_data[0];
        REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // The whole pipeline advances while the skid register is empty.
  assign en       = !skid_valid;
  assign in_stall = skid_valid;
  assign accept   = in_valid && en;
  assign pix_v    = (operation == OP_DRAIN) ? '0 : pixel_in;

  c3bl_raster #(.MAX_WIDTH(MAX_WIDTH)) u_raster (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .geom_write   (geom_write),
    .image_width  (image_width),
    .image_height (image_height),
    .col          (col),
    .info         (info)
  );

  c3bl_line_buf #(.MAX_WIDTH(MAX_WIDTH)) u_line_buf (
    .clk    (clk),
    .accept (accept),
    .col    (col),
    .pixel  (pix_v),
    .move   (en && a_valid),
    .rd_top (rd_top),
    .rd_mid (rd_mid)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
      d_valid <= 1'b0;
    end else if (en) begin
      a_valid <= accept;
      b_valid <= a_valid && a_info.emit;
      c_valid <= b_valid;
      d_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_info <= info;
      a_pix  <= pix_v;
      b_info <= a_info;
    end
  end

  // Window: three column cells, each handing its column to the left neighbour.
  assign feed = '{top: rd_top, mid: rd_mid, bot: a_pix};

  c3bl_cell u_cell_right (
    .clk         (clk),
    .shift       (en && a_valid),
    .col_in      (feed),
    .skip_col    (b_info.skip_right),
    .skip_top    (b_info.skip_top),
    .skip_bottom (b_info.skip_bottom),
    .col_out     (col_right),
    .col_sum     (sum_right)
  );

  c3bl_cell u_cell_centre (
    .clk         (clk),
    .shift       (en && a_valid),
    .col_in      (col_right),
    .skip_col    (1'b0),
    .skip_top    (b_info.skip_top),
    .skip_bottom (b_info.skip_bottom),
    .col_out     (col_centre),
    .col_sum     (sum_centre)
  );

  c3bl_cell u_cell_left (
    .clk         (clk),
    .shift       (en && a_valid),
    .col_in      (col_centre),
    .skip_col    (b_info.skip_left),
    .skip_top    (b_info.skip_top),
    .skip_bottom (b_info.skip_bottom),
    .col_out     (),
    .col_sum     (sum_left)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      c_sum    <= SUM_W'(sum_left) + SUM_W'(sum_centre) + SUM_W'(sum_right);
      c_centre <= col_centre.mid;
      c_last   <= b_info.last;
    end
  end

  // Laplacian is the window sum less nine times the centre.
  always_comb begin
    centre9 = SUM_W'({c_centre, 3'b000}) + SUM_W'(c_centre);
    lap     = $signed({1'b0, c_sum}) - $signed({1'b0, centre9});
    if (lap < 0) begin
      lap_clamped = '0;
    end else if (lap > 13'sd255) begin
      lap_clamped = 8'd255;
    end else begin
      lap_clamped = lap[PIX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_prod <= PROD_W'(c_sum) * PROD_W'(DIV9_RECIP);
      d_lap  <= lap_clamped;
      d_last <= c_last;
    end
  end

  assign result = (kernel_mode == MODE_BOX) ? d_prod[DIV9_SHIFT +: PIX_W] : d_lap;

  // Output register with a skid register behind it.
  assign pop  = out_valid && !out_stall;
  assign push = en && d_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid || pop) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        pixel_out  <= skid_pix;
        frame_last <= skid_last;
      end
    end else if (push) begin
      if (!out_valid || pop) begin
        pixel_out  <= result;
        frame_last <= d_last;
      end else begin
        skid_pix  <= result;
        skid_last <= d_last;
      end
    end
  end

  `C3BL_ASSERT_SAME(a_skid_behind_out, skid_valid, out_valid)
  `C3BL_ASSERT_SAME(a_skid_only_on_stall, $rose(skid_valid), $past(out_valid && out_stall))
  `C3BL_ASSERT_NEXT(a_push_reaches_out, push, out_valid)

endmodule
